[design/dcmt_pkg.sv]
// Shared constants, register indexes and opcodes of the DC motor torque model.
// Also holds the elaboration-time builder of the 2^(-2^-k) factor table.
// No dependencies.
`default_nettype none

package dcmt_pkg;

   localparam int DATA_W         = 32;
   localparam int FRAC_BITS      = 16;
   localparam int EXP_TABLE_BITS = 8;
   localparam int REG_W          = 31;
   localparam int CSR_IDX_W      = 3;
   localparam int REQ_DATA_W     = 3 * DATA_W;
   localparam int RSP_DATA_W     = ((2 * DATA_W + 1 + 7) / 8) * 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TORQUE_CONST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_EMF     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RESISTANCE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COULOMB      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VISCOUS      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DROP     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_DROP    = 3'd6;

   // opcodes
   localparam logic OP_TORQUE   = 1'b0;
   localparam logic OP_VELOCITY = 1'b1;

   // floor square root, bit by bit
   function automatic logic [63:0] isqrt_u64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] rem;
      r   = '0;
      b   = 64'h4000_0000_0000_0000;
      rem = x;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r   = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Q1.30 factor 2^(-2^-k), from the square root chain starting at 0.5
   function automatic logic [30:0] exp_factor(input int k);
      logic [63:0] c;
      c = 64'd1 << 29;
      for (int i = 0; i < k; i++) begin
         c = isqrt_u64(c << 30);
      end
      return c[30:0];
   endfunction

endpackage

`default_nettype wire

[design/dc_motor_torque_model.sv]
// Brushed DC motor torque model: sequencer around one shared multiplier and
// one restoring divider step. Depends on dcmt_pkg.
`default_nettype none

// A torque transfer (opcode 0) runs through the sequencer: a bit-serial
// division for the brush ratio |src|/half (skipped when src or half is
// zero), 8 table multiply steps for 2^-frac, then the drop, back-EMF and
// Kt products on the shared 32x32 multiplier, a bit-serial division for
// Kt*diff/R (skipped when the numerator, Kt or R is zero) and friction.
// Both division loops run on the shared divider step. A velocity transfer
// (opcode 1) goes from idle straight to the output state. The next request
// is accepted once the sequencer is idle, even while the previous result
// still waits on rsp. The user must see that configuration is written only
// while no request is in flight; the block itself does not enforce it.
module dc_motor_torque_model (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // drive_voltage [31:0], load_torque [63:32], velocity [95:64]
   input  wire logic [dcmt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // torque [31:0], corrected_velocity [63:32], stiction [64], zero pad
   output logic [dcmt_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_wen,
   input  wire logic [dcmt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dcmt_pkg::REG_W-1:0]        csr_wdata
);
   import dcmt_pkg::*;

   localparam int NUM_W = 2 * DATA_W + FRAC_BITS;   // dividend width
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam int K_W   = $clog2(EXP_TABLE_BITS);
   localparam int RAT_W = DATA_W + FRAC_BITS;       // brush ratio width
   localparam int MAG_W = DATA_W + FRAC_BITS;       // |diff| width

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DIV_RATIO = 4'd1;
   localparam logic [3:0] ST_EXP       = 4'd2;
   localparam logic [3:0] ST_EXP_END   = 4'd3;
   localparam logic [3:0] ST_DROP      = 4'd4;
   localparam logic [3:0] ST_EMF       = 4'd5;
   localparam logic [3:0] ST_MOTOR_CHK = 4'd6;
   localparam logic [3:0] ST_MUL_LO    = 4'd7;
   localparam logic [3:0] ST_MUL_HI    = 4'd8;
   localparam logic [3:0] ST_DIV_MOTOR = 4'd9;
   localparam logic [3:0] ST_MOTOR_END = 4'd10;
   localparam logic [3:0] ST_VISC      = 4'd11;
   localparam logic [3:0] ST_FRIC      = 4'd12;
   localparam logic [3:0] ST_SAT       = 4'd13;
   localparam logic [3:0] ST_DONE      = 4'd14;

   localparam logic [FRAC_BITS:0] FRAC_ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   localparam logic [62:0]        BIG_LIMIT = 63'd1 << 62;
   localparam logic [63:0]        SAT_MAX   = 64'((64'd1 << (DATA_W - 1)) - 64'd1);
   localparam logic [63:0]        SAT_MIN   = ~SAT_MAX;

   // 2^(-2^-k) factors in Q1.30, constant after elaboration
   logic [30:0] exp_tab [EXP_TABLE_BITS];
   for (genvar g = 0; g < EXP_TABLE_BITS; g++) begin : g_exp_tab
      assign exp_tab[g] = exp_factor(g + 1);
   end

   // configuration
   logic [REG_W-1:0] kt_ff, ke_ff, res_ff, coul_ff, visc_ff, maxd_ff, half_ff;

   // sequencer and datapath
   logic [3:0]              state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [REG_W-1:0]        rem_ff, rem_in;
   logic [63:0]             quo_ff, quo_in;
   logic                    sat_ff, sat_in;
   logic [30:0]             p_ff, p_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [FRAC_BITS:0]      factor_ff, factor_in;
   logic signed [DATA_W-1:0] src_ff, src_in;
   logic signed [DATA_W-1:0] load_ff, load_in;
   logic signed [DATA_W-1:0] vel_ff, vel_in;
   logic [63:0]             acc_ff, acc_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [62:0]             prod_lo_ff, prod_lo_in;
   logic [46:0]             mv_ff, mv_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic                    flag_ff, flag_in;
   logic [DATA_W-1:0]       torque_ff, torque_in;
   logic [DATA_W-1:0]       corr_ff, corr_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   // shared divider step
   logic [REG_W-1:0] div_d;
   logic [REG_W:0]   div_rem_sh;
   logic             div_ge;
   logic             div_last;

   logic                    req_xfer;
   logic signed [DATA_W-1:0] req_src, req_load, req_vel;
   logic [DATA_W-1:0]       vel_abs;
   logic [5:0]              exp_bit_idx;
   logic [30:0]             e_shift;
   logic [FRAC_BITS:0]      e_val;
   logic [30:0]             drop;
   logic [46:0]             em;
   logic [63:0]             acc_abs;
   logic [62:0]             motor_mag;
   logic                    vel_zero;

   assign req_src  = req_tdata[DATA_W-1:0];
   assign req_load = req_tdata[2*DATA_W-1:DATA_W];
   assign req_vel  = req_tdata[3*DATA_W-1:2*DATA_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign vel_abs     = vel_ff[DATA_W-1] ? DATA_W'(-vel_ff) : DATA_W'(vel_ff);
   assign acc_abs     = acc_ff[63] ? 64'(-acc_ff) : acc_ff;
   assign vel_zero    = (vel_ff == '0);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_EXP: begin
            mul_a = 32'(p_ff);
            mul_b = 32'(exp_tab[k_ff]);
         end
         ST_DROP: begin
            mul_a = 32'(maxd_ff);
            mul_b = 32'(factor_ff);
         end
         ST_EMF: begin
            mul_a = vel_abs;
            mul_b = 32'(ke_ff);
         end
         ST_MUL_LO: begin
            mul_a = mag_ff[31:0];
            mul_b = 32'(kt_ff);
         end
         ST_MUL_HI: begin
            mul_a = 32'(mag_ff[MAG_W-1:32]);
            mul_b = 32'(kt_ff);
         end
         ST_VISC: begin
            mul_a = vel_abs;
            mul_b = 32'(visc_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // one restoring division step: bring down the next dividend bit
   assign div_d      = (state_ff == ST_DIV_RATIO) ? half_ff : res_ff;
   assign div_rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge     = (div_rem_sh >= {1'b0, div_d});
   assign div_last   = (cnt_ff == CNT_W'(1));

   assign exp_bit_idx = 6'(FRAC_BITS - 1) - 6'(k_ff);
   assign e_shift     = p_ff >> quo_ff[FRAC_BITS+4:FRAC_BITS];
   assign e_val       = (quo_ff[RAT_W-1:FRAC_BITS] >= 32'd31) ?
                        '0 : e_shift[30:30-FRAC_BITS];
   assign drop        = mul_p[46:FRAC_BITS];
   assign em          = mul_p[62:FRAC_BITS];
   assign motor_mag   = (sat_ff || quo_ff > 64'(BIG_LIMIT)) ? BIG_LIMIT : quo_ff[62:0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      sat_in       = sat_ff;
      p_in         = p_ff;
      k_in         = k_ff;
      factor_in    = factor_ff;
      src_in       = src_ff;
      load_in      = load_ff;
      vel_in       = vel_ff;
      acc_in       = acc_ff;
      mag_in       = mag_ff;
      prod_lo_in   = prod_lo_ff;
      mv_in        = mv_ff;
      prev_in      = prev_ff;
      flag_in      = flag_ff;
      torque_in    = torque_ff;
      corr_in      = corr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               src_in  = req_src;
               load_in = req_load;
               vel_in  = req_vel;
               if (req_tuser == OP_VELOCITY) begin
                  // zero the velocity on a sign reversal and set stiction
                  torque_in = '0;
                  corr_in   = req_vel;
                  if ((req_vel > 0 && prev_ff < 0) || (req_vel < 0 && prev_ff > 0)) begin
                     corr_in = '0;
                     flag_in = 1'b1;
                  end
                  state_in = ST_DONE;
               end else begin
                  corr_in = '0;
                  rem_in  = '0;
                  quo_in  = '0;
                  sat_in  = 1'b0;
                  if (req_src == '0) begin
                     acc_in   = '0;
                     state_in = ST_EMF;
                  end else if (half_ff == '0) begin
                     factor_in = FRAC_ONE;
                     state_in  = ST_DROP;
                  end else begin
                     num_in   = {req_src[DATA_W-1] ? DATA_W'(-req_src) : DATA_W'(req_src),
                                 (NUM_W - DATA_W)'(0)};
                     cnt_in   = CNT_W'(RAT_W);
                     state_in = ST_DIV_RATIO;
                  end
               end
            end
         end

         ST_DIV_RATIO, ST_DIV_MOTOR: begin
            num_in = num_ff << 1;
            sat_in = sat_ff || (quo_ff[63:62] != 2'b00);
            if (div_ge) begin
               rem_in = REG_W'(div_rem_sh - {1'b0, div_d});
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = div_rem_sh[REG_W-1:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (div_last) begin
               if (state_ff == ST_DIV_RATIO) begin
                  p_in     = 31'd1 << 30;
                  k_in     = '0;
                  state_in = ST_EXP;
               end else begin
                  state_in = ST_MOTOR_END;
               end
            end
         end

         ST_EXP: begin
            // multiply in the factor for each set top fraction bit
            if (quo_ff[exp_bit_idx]) begin
               p_in = mul_p[60:30];
            end
            k_in = k_ff + K_W'(1);
            if (k_ff == K_W'(EXP_TABLE_BITS - 1)) begin
               state_in = ST_EXP_END;
            end
         end

         ST_EXP_END: begin
            factor_in = FRAC_ONE - e_val;
            state_in  = ST_DROP;
         end

         ST_DROP: begin
            // pull the source voltage toward zero by the brush drop
            if (src_ff[DATA_W-1]) begin
               acc_in = 64'(src_ff) + 64'(drop);
            end else begin
               acc_in = 64'(src_ff) - 64'(drop);
            end
            state_in = ST_EMF;
         end

         ST_EMF: begin
            if (vel_ff[DATA_W-1]) begin
               acc_in = acc_ff + 64'(em);
            end else begin
               acc_in = acc_ff - 64'(em);
            end
            state_in = ST_MOTOR_CHK;
         end

         ST_MOTOR_CHK: begin
            if (acc_ff == '0 || kt_ff == '0) begin
               acc_in   = 64'(load_ff);
               state_in = ST_VISC;
            end else if (res_ff == '0) begin
               acc_in   = acc_ff[63] ? 64'(load_ff) - 64'(BIG_LIMIT) :
                                       64'(load_ff) + 64'(BIG_LIMIT);
               state_in = ST_VISC;
            end else begin
               mag_in   = acc_abs[MAG_W-1:0];
               state_in = ST_MUL_LO;
            end
         end

         ST_MUL_LO: begin
            prod_lo_in = mul_p[62:0];
            state_in   = ST_MUL_HI;
         end

         ST_MUL_HI: begin
            num_in   = NUM_W'(prod_lo_ff) + (NUM_W'(mul_p[46:0]) << 32);
            cnt_in   = CNT_W'(NUM_W);
            rem_in   = '0;
            quo_in   = '0;
            sat_in   = 1'b0;
            state_in = ST_DIV_MOTOR;
         end

         ST_MOTOR_END: begin
            acc_in   = acc_ff[63] ? 64'(load_ff) - 64'(motor_mag) :
                                    64'(load_ff) + 64'(motor_mag);
            state_in = ST_VISC;
         end

         ST_VISC: begin
            if (vel_zero) begin
               // stiction zone: hold small torques at zero
               if (acc_ff != '0) begin
                  if (64'(coul_ff) > acc_abs) begin
                     acc_in = '0;
                  end else begin
                     acc_in  = acc_ff[63] ? acc_ff + 64'(coul_ff) : acc_ff - 64'(coul_ff);
                     flag_in = 1'b0;
                  end
               end
               state_in = ST_SAT;
            end else begin
               mv_in    = em;
               acc_in   = vel_ff[DATA_W-1] ? acc_ff + 64'(coul_ff) : acc_ff - 64'(coul_ff);
               flag_in  = 1'b0;
               state_in = ST_FRIC;
            end
         end

         ST_FRIC: begin
            acc_in   = vel_ff[DATA_W-1] ? acc_ff + 64'(mv_ff) : acc_ff - 64'(mv_ff);
            state_in = ST_SAT;
         end

         ST_SAT: begin
            if (!acc_ff[63] && acc_ff > SAT_MAX) begin
               torque_in = DATA_W'(SAT_MAX);
            end else if (acc_ff[63] && acc_ff < SAT_MIN) begin
               torque_in = DATA_W'(SAT_MIN);
            end else begin
               torque_in = acc_ff[DATA_W-1:0];
            end
            prev_in  = vel_ff;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({flag_ff, corr_ff, torque_ff});
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         flag_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         flag_ff      <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      sat_ff      <= sat_in;
      p_ff        <= p_in;
      k_ff        <= k_in;
      factor_ff   <= factor_in;
      src_ff      <= src_in;
      load_ff     <= load_in;
      vel_ff      <= vel_in;
      acc_ff      <= acc_in;
      mag_ff      <= mag_in;
      prod_lo_ff  <= prod_lo_in;
      mv_ff       <= mv_in;
      torque_ff   <= torque_in;
      corr_ff     <= corr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         kt_ff   <= '0;
         ke_ff   <= '0;
         res_ff  <= REG_W'(FRAC_ONE);
         coul_ff <= '0;
         visc_ff <= '0;
         maxd_ff <= '0;
         half_ff <= REG_W'(FRAC_ONE);
      end else if (csr_wen) begin
         case (csr_index)
            REG_TORQUE_CONST: kt_ff   <= csr_wdata;
            REG_BACK_EMF:     ke_ff   <= csr_wdata;
            REG_RESISTANCE:   res_ff  <= csr_wdata;
            REG_COULOMB:      coul_ff <= csr_wdata;
            REG_VISCOUS:      visc_ff <= csr_wdata;
            REG_MAX_DROP:     maxd_ff <= csr_wdata;
            REG_HALF_DROP:    half_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire
